// File: rtl/pad_pkg.sv
package pad_pkg;

	// Field and accumulator widths
	localparam int SAMPLE_BITS = 10;
	localparam int FRAC_BITS   = 14;
	localparam int MOM_FRAC    = 12;
	localparam int MEAN_W      = SAMPLE_BITS + FRAC_BITS;
	localparam int MOM_W       = 2 * SAMPLE_BITS + MOM_FRAC;
	localparam int OUT_W       = 18;
	localparam int OUT_SHIFT   = FRAC_BITS - 8;
	localparam int P_DEPTH     = 256;
	localparam int P_W         = 16;
	localparam int CNT_W       = 7;

	// Shared multiplier widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Iterative unit widths
	localparam int ITER_W = 48;
	localparam int QUOT_W = 40;
	localparam int ROOT_W = 24;

	// Configuration register indexes
	localparam logic [1:0] CFG_BETA   = 2'd0;
	localparam logic [1:0] CFG_LAMBDA = 2'd1;
	localparam logic [1:0] CFG_TRAIN  = 2'd2;
	localparam logic [1:0] CFG_KMUL   = 2'd3;

	localparam logic [15:0] BETA_RESET   = 16'd6554;
	localparam logic [15:0] LAMBDA_RESET = 16'd5243;
	localparam logic [6:0]  TRAIN_RESET  = 7'd6;
	localparam logic [3:0]  KMUL_RESET   = 4'd3;

	typedef enum logic [0:0] {
		OP_DIV,
		OP_SQRT
	} iter_op_t;

	typedef struct packed {
		logic       start;
		iter_op_t   op;
		logic [5:0] steps;
	} iter_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic [ROOT_W-1:0] root;
	} iter_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_BRANCH,
		ST_TR_MEAN,
		ST_TR_MEAN_WAIT,
		ST_TR_MOM,
		ST_TR_MOM_WAIT,
		ST_DT_K,
		ST_DT_Z,
		ST_DT_P,
		ST_DT_BP,
		ST_DT_W,
		ST_DT_XW,
		ST_DT_MW,
		ST_DT_MEAN,
		ST_DT_MOMW,
		ST_DT_MOM,
		ST_SIG_MUL,
		ST_SIG_VAR,
		ST_SIG_WAIT,
		ST_OUT
	} state_t;

	typedef logic [P_DEPTH-1:0][P_W-1:0] p_table_t;

	// Gaussian density table, exp(-z^2/2)/sqrt(2*pi) in Q0.16 over z in [0, 8).
	function automatic p_table_t build_p_table();
		longint unsigned a;
		longint unsigned a2;
		longint unsigned a3;
		longint unsigned q;
		longint unsigned qq;
		longint unsigned e;
		longint unsigned r;
		longint unsigned v;
		p_table_t t;
		a  = (64'd32 << 30) / (P_DEPTH * P_DEPTH);
		a2 = (a * a) >> 30;
		a3 = (a2 * a) >> 30;
		q  = (64'd1 << 30) - a + (a2 >> 1) - a3 / 6;
		qq = (q * q) >> 30;
		e  = 64'd1 << 30;
		r  = q;
		for (int i = 0; i < P_DEPTH; i++) begin
			v    = (e * 64'd26145 + (64'd1 << 29)) >> 30;
			t[i] = v[P_W-1:0];
			e    = (e * r) >> 30;
			r    = (r * qq) >> 30;
		end
		return t;
	endfunction

	localparam p_table_t P_TABLE = build_p_table();

endpackage

// File: rtl/pad_in_if.sv
interface pad_in_if;
	logic                         valid;
	logic                         ready;
	logic [pad_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/pad_out_if.sv
interface pad_out_if;
	logic                      valid;
	logic                      ready;
	logic                      anomaly;
	logic                      in_training;
	logic [pad_pkg::OUT_W-1:0] mean_out;
	logic [pad_pkg::OUT_W-1:0] sigma_out;

	modport source (output valid, output anomaly, output in_training, output mean_out,
		output sigma_out, input ready);
	modport sink (input valid, input anomaly, input in_training, input mean_out,
		input sigma_out, output ready);
endinterface

// File: rtl/pad_mul.sv
module pad_mul (
	input  logic                        clk,
	input  logic [pad_pkg::MUL_A_W-1:0] a,
	input  logic [pad_pkg::MUL_B_W-1:0] b,
	output logic [pad_pkg::MUL_P_W-1:0] prod
);

	// Shared multiplier with a registered product.
	always_ff @(posedge clk) begin
		prod <= {{pad_pkg::MUL_B_W{1'b0}}, a} * {{pad_pkg::MUL_A_W{1'b0}}, b};
	end

endmodule

// File: rtl/pad_iter.sv
module pad_iter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pad_pkg::iter_req_t         req,
	input  logic [pad_pkg::ITER_W-1:0] num,
	input  logic [pad_pkg::ROOT_W-1:0] divisor,
	output pad_pkg::iter_rsp_t         rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [5:0]                 cnt_q;
	pad_pkg::iter_op_t          op_q;
	logic [pad_pkg::ITER_W-1:0] acc_q;
	logic [26:0]                rem_q;
	logic [pad_pkg::ROOT_W-1:0] div_q;
	logic [pad_pkg::ROOT_W-1:0] root_q;

	logic [26:0] div_sh;
	logic        div_ge;
	logic [26:0] div_rem;
	logic [26:0] sq_sh;
	logic [26:0] sq_trial;
	logic        sq_ge;
	logic [26:0] sq_rem;

	// One restoring division bit, numerator taken from the top of the shift register.
	always_comb begin
		div_sh  = {rem_q[25:0], acc_q[pad_pkg::ITER_W-1]};
		div_ge  = div_sh >= {3'b0, div_q};
		div_rem = div_ge ? div_sh - {3'b0, div_q} : div_sh;
	end

	// One square root digit, two radicand bits per step.
	always_comb begin
		sq_sh    = {rem_q[24:0], acc_q[pad_pkg::ITER_W-1 -: 2]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_sh >= sq_trial;
		sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= pad_pkg::OP_DIV;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Working registers of the shared divide and root unit.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= num;
			rem_q  <= '0;
			root_q <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			case (op_q)
				pad_pkg::OP_DIV: begin
					acc_q <= {acc_q[pad_pkg::ITER_W-2:0], div_ge};
					rem_q <= div_rem;
				end
				default: begin
					acc_q  <= {acc_q[pad_pkg::ITER_W-3:0], 2'b00};
					rem_q  <= sq_rem;
					root_q <= {root_q[pad_pkg::ROOT_W-2:0], sq_ge};
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q[pad_pkg::QUOT_W-1:0];
	assign rsp.root = root_q;

endmodule

// File: rtl/pewma_anomaly_detector.sv
// Channel   Direction  Payload
// in_ch     sink       sample[9:0]
// out_ch    source     anomaly, in_training, mean_out[17:0], sigma_out[17:0]
// cfg       write      cfg_we, cfg_index[1:0], cfg_data[15:0]
//
// The bit-serial divide and root unit takes 40 steps per training division, 29 for the
// z score and 24 for the root.
// After reset the block is ready at once; the sequencer, configuration, filter state and
// output valid return to their reset values, but the per-sample and output data registers do not.
// A new sample is taken only when the sequencer is idle; a result waiting on out_ch
// stalls the sequencer before it writes the output register.
module pewma_anomaly_detector (
	input  logic     clk,
	input  logic     arst_n,
	pad_in_if.sink   in_ch,
	pad_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pad_pkg::state_t state_q;
	pad_pkg::state_t state_d;

	logic [15:0] beta_q;
	logic [15:0] lambda_q;
	logic [6:0]  train_q;
	logic [3:0]  kmul_q;

	logic [pad_pkg::MEAN_W-1:0] mean_q;
	logic [pad_pkg::MOM_W-1:0]  moment_q;
	logic [pad_pkg::MEAN_W-1:0] sigma_q;
	logic [pad_pkg::CNT_W-1:0]  count_q;
	logic                       seeded_q;

	logic [pad_pkg::SAMPLE_BITS-1:0] x_q;
	logic [pad_pkg::MOM_W-1:0]       x2q_q;
	logic [pad_pkg::MEAN_W-1:0]      d_q;
	logic [7:0]                      idx_q;
	logic [pad_pkg::P_W-1:0]         p_q;
	logic [15:0]                     w_q;
	logic [pad_pkg::MUL_P_W-1:0]     acc_q;
	logic                            anomaly_q;
	logic                            training_q;

	logic                      out_valid_q;
	logic                      out_anomaly_q;
	logic                      out_training_q;
	logic [pad_pkg::OUT_W-1:0] out_mean_q;
	logic [pad_pkg::OUT_W-1:0] out_sigma_q;

	logic [pad_pkg::MUL_A_W-1:0] mul_a;
	logic [pad_pkg::MUL_B_W-1:0] mul_b;
	logic [pad_pkg::MUL_P_W-1:0] prod;

	pad_pkg::iter_req_t         iter_req;
	pad_pkg::iter_rsp_t         iter_rsp;
	logic [pad_pkg::ITER_W-1:0] iter_num;
	logic [pad_pkg::ROOT_W-1:0] iter_div;

	logic [pad_pkg::MEAN_W-1:0] xq;
	logic [pad_pkg::MOM_W-1:0]  x2q_c;
	logic [7:0]                 n_m1;
	logic [7:0]                 n_cur;
	logic                       in_train;
	logic [31:0]                tr_mean_num;
	logic [39:0]                tr_mom_num;
	logic [15:0]                bp;
	logic [16:0]                one_m_bp;
	logic [15:0]                w_c;
	logic [16:0]                one_m_w;
	logic [pad_pkg::MUL_P_W-1:0] blend;
	logic [pad_pkg::MOM_W-1:0]  msq;
	logic [pad_pkg::MOM_W-1:0]  var_c;
	logic                       out_free;
	logic                       in_fire;

	pad_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pad_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (iter_req),
		.num     (iter_num),
		.divisor (iter_div),
		.rsp     (iter_rsp)
	);

	// Shared arithmetic terms.
	always_comb begin
		xq          = {x_q, {pad_pkg::FRAC_BITS{1'b0}}};
		x2q_c       = {prod[19:0], {pad_pkg::MOM_FRAC{1'b0}}};
		n_m1        = {1'b0, count_q} + 8'd1;
		n_cur       = {1'b0, count_q} + 8'd2;
		in_train    = count_q < train_q;
		tr_mean_num = prod[31:0] + {8'b0, xq};
		tr_mom_num  = prod[39:0] + {8'b0, x2q_q};
		bp          = prod[31:16];
		one_m_bp    = 17'h10000 - {1'b0, bp};
		w_c         = prod[31:16];
		one_m_w     = 17'h10000 - {1'b0, w_q};
		blend       = acc_q + prod;
		msq         = prod[47:16];
		var_c       = (moment_q >= msq) ? moment_q - msq : msq - moment_q;
		out_free    = !out_valid_q || out_ch.ready;
		in_fire     = in_ch.valid && in_ch.ready;
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pad_pkg::ST_IDLE:         if (in_ch.valid) state_d = pad_pkg::ST_SQ;
			pad_pkg::ST_SQ:           state_d = pad_pkg::ST_BRANCH;
			pad_pkg::ST_BRANCH: begin
				if (!seeded_q)     state_d = pad_pkg::ST_SIG_MUL;
				else if (in_train) state_d = pad_pkg::ST_TR_MEAN;
				else               state_d = pad_pkg::ST_DT_K;
			end
			pad_pkg::ST_TR_MEAN:      state_d = pad_pkg::ST_TR_MEAN_WAIT;
			pad_pkg::ST_TR_MEAN_WAIT: if (iter_rsp.done) state_d = pad_pkg::ST_TR_MOM;
			pad_pkg::ST_TR_MOM:       state_d = pad_pkg::ST_TR_MOM_WAIT;
			pad_pkg::ST_TR_MOM_WAIT:  if (iter_rsp.done) state_d = pad_pkg::ST_SIG_MUL;
			pad_pkg::ST_DT_K: begin
				if (sigma_q == '0) state_d = pad_pkg::ST_DT_P;
				else               state_d = pad_pkg::ST_DT_Z;
			end
			pad_pkg::ST_DT_Z:         if (iter_rsp.done) state_d = pad_pkg::ST_DT_P;
			pad_pkg::ST_DT_P:         state_d = pad_pkg::ST_DT_BP;
			pad_pkg::ST_DT_BP:        state_d = pad_pkg::ST_DT_W;
			pad_pkg::ST_DT_W:         state_d = pad_pkg::ST_DT_XW;
			pad_pkg::ST_DT_XW:        state_d = pad_pkg::ST_DT_MW;
			pad_pkg::ST_DT_MW:        state_d = pad_pkg::ST_DT_MEAN;
			pad_pkg::ST_DT_MEAN:      state_d = pad_pkg::ST_DT_MOMW;
			pad_pkg::ST_DT_MOMW:      state_d = pad_pkg::ST_DT_MOM;
			pad_pkg::ST_DT_MOM:       state_d = pad_pkg::ST_SIG_MUL;
			pad_pkg::ST_SIG_MUL:      state_d = pad_pkg::ST_SIG_VAR;
			pad_pkg::ST_SIG_VAR:      state_d = pad_pkg::ST_SIG_WAIT;
			pad_pkg::ST_SIG_WAIT:     if (iter_rsp.done) state_d = pad_pkg::ST_OUT;
			pad_pkg::ST_OUT:          if (out_free) state_d = pad_pkg::ST_IDLE;
			default:                  state_d = pad_pkg::ST_IDLE;
		endcase
	end

	// Operand selection for the multiplier and the iterative unit.
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		iter_req = '0;
		iter_num = '0;
		iter_div = '0;
		unique case (state_q)
			pad_pkg::ST_SQ: begin
				mul_a = {22'b0, x_q};
				mul_b = {14'b0, x_q};
			end
			pad_pkg::ST_BRANCH: begin
				if (in_train) begin
					mul_a = {8'b0, mean_q};
					mul_b = {16'b0, n_m1};
				end else begin
					mul_a = {8'b0, sigma_q};
					mul_b = {20'b0, kmul_q};
				end
			end
			pad_pkg::ST_TR_MEAN: begin
				iter_req = '{start: 1'b1, op: pad_pkg::OP_DIV, steps: 6'd40};
				iter_num = {8'b0, tr_mean_num, 8'b0};
				iter_div = {16'b0, n_cur};
			end
			pad_pkg::ST_TR_MEAN_WAIT: begin
				mul_a = moment_q;
				mul_b = {16'b0, n_m1};
			end
			pad_pkg::ST_TR_MOM: begin
				iter_req = '{start: 1'b1, op: pad_pkg::OP_DIV, steps: 6'd40};
				iter_num = {tr_mom_num, 8'b0};
				iter_div = {16'b0, n_cur};
			end
			pad_pkg::ST_DT_K: begin
				if (sigma_q != '0) begin
					iter_req = '{start: 1'b1, op: pad_pkg::OP_DIV, steps: 6'd29};
					iter_num = {d_q, 24'b0};
					iter_div = sigma_q;
				end
			end
			pad_pkg::ST_DT_BP: begin
				mul_a = {16'b0, beta_q};
				mul_b = {8'b0, p_q};
			end
			pad_pkg::ST_DT_W: begin
				mul_a = {16'b0, lambda_q};
				mul_b = {7'b0, one_m_bp};
			end
			pad_pkg::ST_DT_XW: begin
				mul_a = {8'b0, xq};
				mul_b = {8'b0, w_c};
			end
			pad_pkg::ST_DT_MW: begin
				mul_a = {8'b0, mean_q};
				mul_b = {7'b0, one_m_w};
			end
			pad_pkg::ST_DT_MEAN: begin
				mul_a = x2q_q;
				mul_b = {8'b0, w_q};
			end
			pad_pkg::ST_DT_MOMW: begin
				mul_a = moment_q;
				mul_b = {7'b0, one_m_w};
			end
			pad_pkg::ST_SIG_MUL: begin
				mul_a = {8'b0, mean_q};
				mul_b = mean_q;
			end
			pad_pkg::ST_SIG_VAR: begin
				iter_req = '{start: 1'b1, op: pad_pkg::OP_SQRT, steps: 6'd24};
				iter_num = {var_c, 16'b0};
			end
			default: begin
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q   <= pad_pkg::BETA_RESET;
			lambda_q <= pad_pkg::LAMBDA_RESET;
			train_q  <= pad_pkg::TRAIN_RESET;
			kmul_q   <= pad_pkg::KMUL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pad_pkg::CFG_BETA:   beta_q   <= cfg_data;
				pad_pkg::CFG_LAMBDA: lambda_q <= cfg_data;
				pad_pkg::CFG_TRAIN:  train_q  <= cfg_data[6:0];
				pad_pkg::CFG_KMUL:   kmul_q   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Filter state: mean, moment, sigma and the training counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= '0;
			moment_q <= '0;
			sigma_q  <= pad_pkg::MEAN_W'(1 << pad_pkg::FRAC_BITS);
			count_q  <= '0;
			seeded_q <= 1'b0;
		end else begin
			case (state_q)
				pad_pkg::ST_BRANCH: begin
					if (!seeded_q) begin
						mean_q   <= xq;
						moment_q <= x2q_c;
						seeded_q <= 1'b1;
					end
				end
				pad_pkg::ST_TR_MEAN_WAIT: begin
					if (iter_rsp.done) mean_q <= iter_rsp.quot[pad_pkg::MEAN_W-1:0];
				end
				pad_pkg::ST_TR_MOM_WAIT: begin
					if (iter_rsp.done) begin
						moment_q <= iter_rsp.quot[pad_pkg::MOM_W-1:0];
						count_q  <= count_q + 7'd1;
					end
				end
				pad_pkg::ST_DT_MEAN: mean_q   <= blend[39:16];
				pad_pkg::ST_DT_MOM:  moment_q <= blend[47:16];
				pad_pkg::ST_SIG_WAIT: begin
					if (iter_rsp.done) sigma_q <= iter_rsp.root;
				end
				default: begin
				end
			endcase
		end
	end

	// Per-sample working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pad_pkg::ST_IDLE: begin
				if (in_fire) x_q <= in_ch.sample;
			end
			pad_pkg::ST_BRANCH: begin
				x2q_q      <= x2q_c;
				training_q <= !seeded_q || in_train;
				anomaly_q  <= 1'b0;
				d_q        <= (xq >= mean_q) ? xq - mean_q : mean_q - xq;
			end
			pad_pkg::ST_DT_K: begin
				anomaly_q <= {4'b0, d_q} >= prod[27:0];
				idx_q     <= 8'hFF;
			end
			pad_pkg::ST_DT_Z: begin
				if (iter_rsp.done) begin
					idx_q <= (iter_rsp.quot[28:8] != '0) ? 8'hFF : iter_rsp.quot[7:0];
				end
			end
			pad_pkg::ST_DT_P:    p_q   <= pad_pkg::P_TABLE[idx_q];
			pad_pkg::ST_DT_XW:   w_q   <= w_c;
			pad_pkg::ST_DT_MW:   acc_q <= prod;
			pad_pkg::ST_DT_MOMW: acc_q <= prod;
			default: begin
			end
		endcase
	end

	// Output register: one result transaction per sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pad_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pad_pkg::ST_OUT && out_free) begin
			out_anomaly_q  <= anomaly_q;
			out_training_q <= training_q;
			out_mean_q     <= mean_q[pad_pkg::MEAN_W-1:pad_pkg::OUT_SHIFT];
			out_sigma_q    <= sigma_q[pad_pkg::MEAN_W-1:pad_pkg::OUT_SHIFT];
		end
	end

	assign in_ch.ready        = (state_q == pad_pkg::ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.anomaly     = out_anomaly_q;
	assign out_ch.in_training = out_training_q;
	assign out_ch.mean_out    = out_mean_q;
	assign out_ch.sigma_out   = out_sigma_q;

	// An accepted sample always starts the sequencer.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != pad_pkg::ST_IDLE)
		else $error("sample accepted but sequencer stayed idle");

	// A result only appears after the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == pad_pkg::ST_OUT)
		else $error("result raised outside the output state");

	// Training results never flag an anomaly.
	a_train_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.anomaly && out_ch.in_training))
		else $error("anomaly flagged during training");

	// The divider is never started with a zero divisor.
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(iter_req.start && iter_req.op == pad_pkg::OP_DIV) |-> iter_div != '0)
		else $error("division started with zero divisor");

endmodule
